// ===== src/tpc_pkg.sv =====
`default_nettype none

package tpc_pkg;

   // word widths fixed by the value and totient fields
   localparam int unsigned DATA_W  = 17;
   // trial divisor: d*d stays at most one step above a 17-bit cofactor
   localparam int unsigned TRIAL_W = 9;
   localparam int unsigned SQ_W    = 2 * TRIAL_W;

   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [TRIAL_W-1:0] trial_type;

   // scratch memory entries
   typedef enum logic {
      ADDR_ACC,
      ADDR_REST
   } addr_type;

   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      data_type wr_data;
      logic     rd_en;
      addr_type rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic     start;
      data_type dividend;
      data_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      data_type quotient;
      data_type remainder;
   } div_rsp_type;

endpackage

`default_nettype wire

// ===== src/totient_prime_check.sv =====
`default_nettype none

// A value at or above VALUE_LIMIT is answered straight from idle, and 0 and 1 need no divide;
//   otherwise each trial divisor costs a divide on the shared divider plus read and
//   compare, with up to 361 divisors for a prime near the top.
// Throughput: one word at a time; busy stays high until the result strobe is set.
// The receiver cannot stall: rsp_valid is a one-cycle strobe.
// Reset (synchronous, active high) clears the sequencer, divider and strobe.
module totient_prime_check #(
   parameter int unsigned VALUE_LIMIT = 131072
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   output logic                     busy,
   input  wire  [tpc_pkg::DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   output logic [tpc_pkg::DATA_W-1:0] rsp_totient,
   output logic                     rsp_totient_is_prime
);

   localparam int unsigned TW = tpc_pkg::TRIAL_W;
   localparam int unsigned SW = tpc_pkg::SQ_W;

   // Sequencer states.
   // Totient pass: CHECK reads the cofactor, CMP tests d*d against it and starts
   // the divide, DIVR takes the result. While d keeps dividing the cofactor the
   // square test is skipped (in_while). ACC_* remove acc/divisor from the result.
   // Prime pass: PRIME_* test the totient word held in the scratch store; a totient
   // above 2 is even, so this pass ends at the first divisor.
   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_CHECK,
      S_CMP,
      S_DIVR,
      S_ACC_RD,
      S_ACC_DIV,
      S_ACC_WAIT,
      S_PRIME_RD,
      S_PRIME_CMP,
      S_PRIME_WAIT
   } state_type;

   state_type            state_ff;
   tpc_pkg::data_type    value_ff;
   tpc_pkg::trial_type   d_ff;
   tpc_pkg::data_type    divisor_ff;
   logic                 in_while_ff;
   logic                 ret_final_ff;   // result update came from the leftover prime
   logic                 rsp_valid_ff;
   tpc_pkg::data_type    rsp_totient_ff;
   logic                 rsp_prime_ff;

   tpc_pkg::mem_req_type mem_req;
   tpc_pkg::data_type    rd_data;
   tpc_pkg::div_req_type div_req;
   tpc_pkg::div_rsp_type div_rsp;

   logic [SW-1:0] sq;
   logic          sq_above;
   logic          above_one;
   logic          in_range;
   logic          accept;
   logic          rem_zero;

   assign sq        = {{TW{1'b0}}, d_ff} * {{TW{1'b0}}, d_ff};
   assign sq_above  = sq > {{(SW - tpc_pkg::DATA_W){1'b0}}, rd_data};
   assign above_one = rd_data > tpc_pkg::DATA_W'(1);
   assign in_range  = 32'(req_value) < VALUE_LIMIT;
   assign accept    = start && !busy;
   assign rem_zero  = div_rsp.remainder == '0;

   tpc_scratch u_scratch (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   tpc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // scratch store accesses; a write and a read of the same word never share a cycle
   always_comb begin
      mem_req         = '0;
      mem_req.wr_addr = tpc_pkg::ADDR_ACC;
      mem_req.rd_addr = tpc_pkg::ADDR_ACC;
      case (state_ff)
         S_IDLE: begin
            mem_req.wr_en   = accept && in_range;
            mem_req.wr_data = req_value;
         end
         S_INIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tpc_pkg::ADDR_REST;
            mem_req.wr_data = value_ff;
         end
         S_CHECK: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = tpc_pkg::ADDR_REST;
         end
         S_DIVR: begin
            mem_req.wr_en   = div_rsp.done && rem_zero;
            mem_req.wr_addr = tpc_pkg::ADDR_REST;
            mem_req.wr_data = div_rsp.quotient;
         end
         S_ACC_RD: begin
            mem_req.rd_en = 1'b1;
         end
         S_ACC_WAIT: begin
            // rd_data still holds the result word read in ACC_RD
            mem_req.wr_en   = div_rsp.done;
            mem_req.wr_data = rd_data - div_rsp.quotient;
         end
         S_PRIME_RD: begin
            mem_req.rd_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      div_req.dividend = rd_data;
      div_req.divisor  = divisor_ff;
      case (state_ff)
         S_CMP:       div_req.start = in_while_ff || !sq_above;
         S_ACC_DIV:   div_req.start = 1'b1;
         S_PRIME_CMP: div_req.start = above_one && !sq_above;
         default:     div_req.start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (in_range) begin
                     value_ff    <= req_value;
                     d_ff        <= TW'(2);
                     in_while_ff <= 1'b0;
                     state_ff    <= S_INIT;
                  end else begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_totient_ff <= '0;
                     rsp_prime_ff   <= 1'b0;
                  end
               end
            end
            S_INIT: begin
               state_ff <= S_CHECK;
            end
            S_CHECK: begin
               divisor_ff <= tpc_pkg::DATA_W'(d_ff);
               state_ff   <= S_CMP;
            end
            S_CMP: begin
               if (in_while_ff || !sq_above) begin
                  state_ff <= S_DIVR;
               end else if (above_one) begin
                  // leftover cofactor is prime
                  divisor_ff   <= rd_data;
                  ret_final_ff <= 1'b1;
                  state_ff     <= S_ACC_RD;
               end else begin
                  d_ff     <= TW'(2);
                  state_ff <= S_PRIME_RD;
               end
            end
            S_DIVR: begin
               if (div_rsp.done) begin
                  if (rem_zero) begin
                     in_while_ff <= 1'b1;
                     state_ff    <= S_CHECK;
                  end else if (in_while_ff) begin
                     in_while_ff  <= 1'b0;
                     ret_final_ff <= 1'b0;
                     state_ff     <= S_ACC_RD;
                  end else begin
                     d_ff     <= d_ff + TW'(1);
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_ACC_RD: begin
               state_ff <= S_ACC_DIV;
            end
            S_ACC_DIV: begin
               state_ff <= S_ACC_WAIT;
            end
            S_ACC_WAIT: begin
               if (div_rsp.done) begin
                  if (ret_final_ff) begin
                     d_ff     <= TW'(2);
                     state_ff <= S_PRIME_RD;
                  end else begin
                     d_ff     <= d_ff + TW'(1);
                     state_ff <= S_CHECK;
                  end
               end
            end
            S_PRIME_RD: begin
               divisor_ff <= tpc_pkg::DATA_W'(d_ff);
               state_ff   <= S_PRIME_CMP;
            end
            S_PRIME_CMP: begin
               if (!above_one || sq_above) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_totient_ff <= rd_data;
                  rsp_prime_ff   <= above_one;
                  state_ff       <= S_IDLE;
               end else begin
                  state_ff <= S_PRIME_WAIT;
               end
            end
            S_PRIME_WAIT: begin
               if (div_rsp.done) begin
                  if (rem_zero) begin
                     rsp_valid_ff   <= 1'b1;
                     rsp_totient_ff <= rd_data;
                     rsp_prime_ff   <= 1'b0;
                     state_ff       <= S_IDLE;
                  end else begin
                     d_ff     <= d_ff + TW'(1);
                     state_ff <= S_PRIME_RD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                 = state_ff != S_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_totient          = rsp_totient_ff;
   assign rsp_totient_is_prime = rsp_prime_ff;

`ifndef SYNTHESIS
   // the result strobe only appears once the sequencer is back at rest
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // an in-range word always starts a computation
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && in_range) |=> busy)
      else $error("accepted word did not start");

   // divider results arrive only where the sequencer waits for them
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIVR || state_ff == S_ACC_WAIT ||
                        state_ff == S_PRIME_WAIT))
      else $error("divider finished outside a wait state");

   // a prime totient is never below two
   a_prime_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_totient_is_prime) |-> (rsp_totient >= tpc_pkg::DATA_W'(2)))
      else $error("prime flag on a totient below two");
`endif

endmodule

`default_nettype wire

// ===== src/tpc_scratch.sv =====
`default_nettype none

// two-word working store, one write and one registered read per cycle
module tpc_scratch (
   input  wire                       clock,
   input  wire tpc_pkg::mem_req_type mem_req,
   output tpc_pkg::data_type         rd_data
);

   tpc_pkg::data_type mem [2];
   tpc_pkg::data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/tpc_divider.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module tpc_divider (
   input  wire                       clock,
   input  wire                       reset,
   input  wire tpc_pkg::div_req_type div_req,
   output tpc_pkg::div_rsp_type      div_rsp
);

   localparam int unsigned W     = tpc_pkg::DATA_W;
   localparam int unsigned CNT_W = $clog2(W);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   tpc_pkg::data_type rem_ff;
   tpc_pkg::data_type quo_ff;
   tpc_pkg::data_type dsr_ff;

   logic [W+1:0] shifted;
   logic [W+1:0] diff;
   logic         neg;

   assign shifted = {1'b0, rem_ff, quo_ff[W-1]};
   assign diff    = shifted - {2'b00, dsr_ff};
   assign neg     = diff[W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            rem_ff <= neg ? shifted[W-1:0] : diff[W-1:0];
            quo_ff <= {quo_ff[W-2:0], ~neg};
            if (cnt_ff == CNT_W'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            rem_ff  <= '0;
            quo_ff  <= div_req.dividend;
            dsr_ff  <= div_req.divisor;
         end
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
module tb_top;

   // Every 17-bit value lies below this bound, so the out-of-range path
   // of the block cannot be reached from the port at this setting.
   localparam int unsigned VALUE_LIMIT = 131072;
   localparam int unsigned DATA_W      = tpc_pkg::DATA_W;

   // Sized for the worst word; ~105 words plus gaps, taken ten times over.
   localparam int unsigned CYCLE_LIMIT = 8_000_000;
   localparam int unsigned TAIL_CYCLES = 50;

   typedef struct packed {
      tpc_pkg::data_type totient;
      logic              is_prime;
   } totient_word_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   tpc_pkg::data_type req_value = '0;
   logic              busy;
   logic              rsp_valid;
   tpc_pkg::data_type rsp_totient;
   logic              rsp_totient_is_prime;

   // totients still owed by the block, oldest first
   totient_word_type totients_due[$];
   int unsigned      failures    = 0;
   int unsigned      cycle_count = 0;

   totient_prime_check #(
      .VALUE_LIMIT(VALUE_LIMIT)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_totient         (rsp_totient),
      .rsp_totient_is_prime(rsp_totient_is_prime)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Phi by trial division on the shrinking cofactor, then a primality test
   // of phi itself; 0 and 1 are not prime.
   function automatic totient_word_type predict_totient(input tpc_pkg::data_type value);
      int unsigned      acc;
      int unsigned      rest;
      int unsigned      d;
      totient_word_type word;
      word.totient  = '0;
      word.is_prime = 1'b0;
      if (value < VALUE_LIMIT) begin
         acc  = value;
         rest = value;
         for (d = 2; d * d <= rest; d++) begin
            if (rest % d == 0) begin
               acc -= acc / d;
               while (rest % d == 0)
                  rest /= d;
            end
         end
         // whatever is left above 1 is a prime factor
         if (rest > 1)
            acc -= acc / rest;
         word.totient  = acc[DATA_W-1:0];
         word.is_prime = (acc >= 2);
         for (d = 2; word.is_prime && d * d <= acc; d++) begin
            if (acc % d == 0)
               word.is_prime = 1'b0;
         end
      end
      return word;
   endfunction

   // Raise start with the word and hold it until an edge sees busy low.
   // start is left high: the caller either sends again in the same step
   // or lowers it through hold_off / wait_drained.
   task automatic send_word(input tpc_pkg::data_type value);
      start     <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      totients_due = {totients_due, predict_totient(value)};
   endtask

   // cycles must be at least 1, so start is never lowered and raised in one step
   task automatic hold_off(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // about 6 in 100 words are followed by a gap; long gaps outlast short words
   task automatic maybe_pause();
      if ($urandom_range(0, 99) < 6)
         hold_off($urandom_range(1, 300));
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (totients_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mix of shapes: full range mostly, plus small values, powers of two,
   // squares (d*d right at the cofactor bound), even values and the top end.
   function automatic tpc_pkg::data_type draw_value();
      int unsigned root;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return tpc_pkg::data_type'($urandom_range(0, 131071));
         5: return tpc_pkg::data_type'($urandom_range(0, 64));
         6: return tpc_pkg::data_type'(1 << $urandom_range(0, 16));
         7: begin
            root = $urandom_range(2, 362);
            return tpc_pkg::data_type'(root * root);
         end
         8: return tpc_pkg::data_type'($urandom_range(0, 131071) &
                                       ~((1 << $urandom_range(1, 12)) - 1));
         default: return tpc_pkg::data_type'(131071 - $urandom_range(0, 255));
      endcase
   endfunction

   // Edge cases: zero and one (never prime), the only values whose totient is
   // prime (3, 4, 6), prime powers and squares of primes near the top, the
   // Mersenne prime at the very top, and a product of many small primes.
   task automatic test_directed_values();
      int unsigned corner_values[] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 12, 30030, 65536,
                                       65537, 128881, 130321, 131044, 131070, 131071,
                                       9, 25, 121, 510, 100003, 131072 - 2};
      foreach (corner_values[i])
         send_word(tpc_pkg::data_type'(corner_values[i]));
      wait_drained();
   endtask

   // back-to-back words, start never dropped
   task automatic test_unbroken_stream();
      repeat (40)
         send_word(draw_value());
      hold_off(1);
   endtask

   // random gaps, and midway the sender holds off until every result is in
   task automatic test_stream_with_gaps();
      for (int i = 0; i < 40; i++) begin
         send_word(draw_value());
         maybe_pause();
         if (i == 20)
            wait_drained();
      end
   endtask

   // Each strobe is taken at the edge that ends its cycle; no backpressure.
   always @(posedge clock) begin : check_results
      totient_word_type due;
      if (!reset && rsp_valid) begin
         if (totients_due.size() == 0) begin
            $error("unexpected result word: totient %0d, is_prime %0b",
                   rsp_totient, rsp_totient_is_prime);
            failures++;
         end else begin
            due = totients_due.pop_front();
            if (rsp_totient !== due.totient) begin
               $error("totient: expected %0d, actual %0d", due.totient, rsp_totient);
               failures++;
            end
            if (rsp_totient_is_prime !== due.is_prime) begin
               $error("totient_is_prime: expected %0b, actual %0b",
                      due.is_prime, rsp_totient_is_prime);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** totient_prime_check: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_values();
      test_unbroken_stream();
      test_stream_with_gaps();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("** totient_prime_check: PASSED **");
      else
         $display("** totient_prime_check: FAILED **");
      $finish;
   end

endmodule
